// File: rtl/iau_pkg.sv
// iau_pkg: shared types, codes and helper functions of the interval arithmetic unit
// no dependencies

package iau_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned Q_W = 32;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  // product index: b bound then a bound
  localparam logic [1:0] P_LL = 2'd0;
  localparam logic [1:0] P_LU = 2'd1;
  localparam logic [1:0] P_UL = 2'd2;
  localparam logic [1:0] P_UU = 2'd3;

  typedef struct packed {
    logic [1:0] lo_a;
    logic [1:0] lo_b;
    logic [1:0] hi_a;
    logic [1:0] hi_b;
  } mul_sel_t;

  typedef struct packed {
    logic signed [Q_W-1:0] lo;
    logic signed [Q_W-1:0] hi;
    logic                  ovf;
    logic                  is_div;
    logic                  derr;
  } iau_res_t;

  // saturate a wide signed value to q range, msb of result is the overflow flag
  function automatic logic [Q_W:0] sat64(input logic signed [63:0] v);
    logic [Q_W:0] r;
    if (!v[63] && (|v[62:Q_W-1])) begin
      r = {1'b1, 1'b0, {(Q_W-1){1'b1}}};
    end else if (v[63] && !(&v[62:Q_W-1])) begin
      r = {1'b1, 1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, v[Q_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [Q_W:0] sat33(input logic signed [Q_W:0] v);
    logic [Q_W:0] r;
    if (v[Q_W] != v[Q_W-1]) begin
      r = {1'b1, v[Q_W], {(Q_W-1){!v[Q_W]}}};
    end else begin
      r = {1'b0, v[Q_W-1:0]};
    end
    return r;
  endfunction

  // divider depth: operand stage, one stage per quotient bit, round and saturate
  function automatic int unsigned div_lat(input int unsigned frac);
    return Q_W + frac + 3;
  endfunction

endpackage

// File: rtl/iau_div.sv
// iau_div: pipelined restoring divider for one q bound, rounding down or up
// depends on iau_pkg

module iau_div #(
  parameter int unsigned FRAC_BITS = iau_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        ce_i,
  input  logic signed [iau_pkg::Q_W-1:0] num_i,
  input  logic signed [iau_pkg::Q_W-1:0] den_i,
  input  logic                        rnd_up_i,
  output logic signed [iau_pkg::Q_W-1:0] quo_o,
  output logic                        ovf_o
);
  import iau_pkg::*;

  localparam int unsigned NW = Q_W + FRAC_BITS;
  localparam int unsigned QW = NW + 2;

  typedef struct packed {
    logic neg;
    logic up;
    logic dz;
    logic nz;
    logic nsgn;
  } div_ctl_t;

  logic [NW-1:0]  nq_q  [NW+1];
  logic [Q_W-1:0] rem_q [NW+1];
  logic [Q_W-1:0] dv_q  [NW+1];
  div_ctl_t       ctl_q [NW+1];

  logic [Q_W-1:0] n_abs, d_abs;
  div_ctl_t       ctl_d;

  always_comb begin
    n_abs = num_i[Q_W-1] ? Q_W'(-num_i) : num_i;
    d_abs = den_i[Q_W-1] ? Q_W'(-den_i) : den_i;
    ctl_d.neg  = num_i[Q_W-1] ^ den_i[Q_W-1];
    ctl_d.up   = rnd_up_i;
    ctl_d.dz   = (den_i == '0);
    ctl_d.nz   = (num_i == '0);
    ctl_d.nsgn = num_i[Q_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      nq_q[0]  <= NW'({n_abs, {FRAC_BITS{1'b0}}});
      rem_q[0] <= '0;
      dv_q[0]  <= d_abs;
      ctl_q[0] <= ctl_d;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [Q_W:0] trial, diff;
    logic         ge;
    always_comb begin
      trial = {rem_q[k], nq_q[k][NW-1]};
      diff  = trial - {1'b0, dv_q[k]};
      ge    = (trial >= {1'b0, dv_q[k]});
    end
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[k+1] <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
        nq_q[k+1]  <= {nq_q[k][NW-2:0], ge};
        dv_q[k+1]  <= dv_q[k];
        ctl_q[k+1] <= ctl_q[k];
      end
    end
  end

  // rounding fix-up
  logic signed [QW-1:0] val_d, val_q;
  div_ctl_t             fctl_q;
  logic                 rnz;

  always_comb begin
    rnz = |rem_q[NW];
    if (ctl_q[NW].neg) begin
      val_d = QW'(~{2'b00, nq_q[NW]}) + QW'(!(rnz && !ctl_q[NW].up));
    end else begin
      val_d = QW'({2'b00, nq_q[NW]}) + QW'(rnz && ctl_q[NW].up);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      val_q  <= val_d;
      fctl_q <= ctl_q[NW];
    end
  end

  // saturation and zero divisor
  logic [Q_W:0] sat_r;
  logic [Q_W:0] out_d;
  logic [Q_W:0] out_q;

  always_comb begin
    sat_r = sat64(64'(val_q));
    if (fctl_q.dz) begin
      if (fctl_q.nz) begin
        out_d = '0;
      end else if (fctl_q.nsgn) begin
        out_d = {1'b1, 1'b1, {(Q_W-1){1'b0}}};
      end else begin
        out_d = {1'b1, 1'b0, {(Q_W-1){1'b1}}};
      end
    end else begin
      out_d = sat_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      out_q <= out_d;
    end
  end

  assign quo_o = out_q[Q_W-1:0];
  assign ovf_o = out_q[Q_W];

endmodule

// File: rtl/interval_arithmetic_unit.sv
// interval_arithmetic_unit: pipelined q-format interval add, subtract, multiply, divide
// depends on iau_pkg and iau_div
//
// channel  dir  tdata                               tuser
// s_axis   in   a_low, a_high, b_low, b_high        action
// m_axis   out  r_low, r_high                       div_error, overflow
//
// one transaction in and one out per cycle whenever the stages advance; the path from
// input to output register runs through the one-bit-per-stage divider pipeline
// all stages advance together whenever the output register is free or taken
// reset clears the valid bits only; no clearing pass

module interval_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = iau_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // a_low, a_high, b_low, b_high
  input  logic [1:0]   s_axis_tuser,   // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // r_low, r_high
  output logic [1:0]   m_axis_tuser    // div_error, overflow
);
  import iau_pkg::*;

  localparam int unsigned DL  = div_lat(FRAC_BITS);
  localparam int unsigned DLY = DL - 3;
  localparam logic [63:0] RND_MASK = 64'((64'd1 << FRAC_BITS) - 64'd1);

  logic ce;
  logic mv_q;

  assign ce            = !mv_q || m_axis_tready;
  assign s_axis_tready = ce;

  // input stage
  logic                  v1_q;
  action_e               op1_q;
  logic signed [Q_W-1:0] al_q, ah_q, bl_q, bh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ce) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      op1_q <= action_e'(s_axis_tuser);
      al_q  <= s_axis_tdata[31:0];
      ah_q  <= s_axis_tdata[63:32];
      bl_q  <= s_axis_tdata[95:64];
      bh_q  <= s_axis_tdata[127:96];
    end
  end

  // case selection
  mul_sel_t              msel;
  logic signed [Q_W-1:0] dn_lo, dd_lo, dn_hi, dd_hi;
  logic                  derr1;

  always_comb begin
    if (!bl_q[Q_W-1]) begin
      if (!al_q[Q_W-1])  msel = '{P_LL, P_LL, P_UU, P_UU};
      else if (ah_q > 0) msel = '{P_UL, P_UL, P_UU, P_UU};
      else               msel = '{P_UL, P_UL, P_LU, P_LU};
    end else if (bh_q > 0) begin
      if (!al_q[Q_W-1])       msel = '{P_LU, P_LU, P_UU, P_UU};
      else if (ah_q <= 0)     msel = '{P_UL, P_UL, P_LL, P_LL};
      else                    msel = '{P_LU, P_UL, P_LL, P_UU};
    end else begin
      if (!al_q[Q_W-1])  msel = '{P_LU, P_LU, P_UL, P_UL};
      else if (ah_q > 0) msel = '{P_LU, P_LU, P_LL, P_LL};
      else               msel = '{P_UU, P_UU, P_LL, P_LL};
    end
  end

  always_comb begin
    derr1 = 1'b0;
    dn_lo = al_q;
    dd_lo = bl_q;
    dn_hi = ah_q;
    dd_hi = bl_q;
    if (bl_q > 0) begin
      if (!al_q[Q_W-1]) begin
        dn_lo = al_q; dd_lo = bh_q; dn_hi = ah_q; dd_hi = bl_q;
      end else if (ah_q > 0) begin
        dn_lo = al_q; dd_lo = bl_q; dn_hi = ah_q; dd_hi = bl_q;
      end else begin
        dn_lo = al_q; dd_lo = bl_q; dn_hi = ah_q; dd_hi = bh_q;
      end
    end else if (bh_q[Q_W-1]) begin
      if (!al_q[Q_W-1]) begin
        dn_lo = ah_q; dd_lo = bh_q; dn_hi = al_q; dd_hi = bl_q;
      end else if (ah_q > 0) begin
        dn_lo = ah_q; dd_lo = bh_q; dn_hi = al_q; dd_hi = bh_q;
      end else begin
        dn_lo = ah_q; dd_lo = bl_q; dn_hi = al_q; dd_hi = bh_q;
      end
    end else begin
      derr1 = 1'b1;
    end
  end

  // multiplier stage and add/sub
  logic signed [63:0]    p_d [4];
  logic signed [63:0]    p_q [4];
  logic signed [Q_W:0]   as_lo, as_hi;
  logic [Q_W:0]          as_lo_s, as_hi_s;
  mul_sel_t              msel2_q;
  action_e               op2_q;
  logic                  derr2_q;
  logic [Q_W:0]          as_lo2_q, as_hi2_q;

  always_comb begin
    p_d[P_LL] = bl_q * al_q;
    p_d[P_LU] = bl_q * ah_q;
    p_d[P_UL] = bh_q * al_q;
    p_d[P_UU] = bh_q * ah_q;
    if (op1_q == ACT_SUB) begin
      as_lo = (Q_W+1)'(al_q) - (Q_W+1)'(bh_q);
      as_hi = (Q_W+1)'(ah_q) - (Q_W+1)'(bl_q);
    end else begin
      as_lo = (Q_W+1)'(al_q) + (Q_W+1)'(bl_q);
      as_hi = (Q_W+1)'(ah_q) + (Q_W+1)'(bh_q);
    end
    as_lo_s = sat33(as_lo);
    as_hi_s = sat33(as_hi);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) p_q[i] <= p_d[i];
      msel2_q  <= msel;
      op2_q    <= op1_q;
      derr2_q  <= (op1_q == ACT_DIV) && derr1;
      as_lo2_q <= as_lo_s;
      as_hi2_q <= as_hi_s;
    end
  end

  // rounding and saturation of the selected products
  logic signed [63:0] la, lb, ha, hb;
  logic [Q_W:0]       la_s, lb_s, ha_s, hb_s;
  logic [Q_W:0]       la3_q, lb3_q, ha3_q, hb3_q;
  action_e            op3_q;
  logic               derr3_q;
  logic [Q_W:0]       as_lo3_q, as_hi3_q;

  always_comb begin
    la   = p_q[msel2_q.lo_a] >>> FRAC_BITS;
    lb   = p_q[msel2_q.lo_b] >>> FRAC_BITS;
    ha   = (p_q[msel2_q.hi_a] + $signed(RND_MASK)) >>> FRAC_BITS;
    hb   = (p_q[msel2_q.hi_b] + $signed(RND_MASK)) >>> FRAC_BITS;
    la_s = sat64(la);
    lb_s = sat64(lb);
    ha_s = sat64(ha);
    hb_s = sat64(hb);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      la3_q    <= la_s;
      lb3_q    <= lb_s;
      ha3_q    <= ha_s;
      hb3_q    <= hb_s;
      op3_q    <= op2_q;
      derr3_q  <= derr2_q;
      as_lo3_q <= as_lo2_q;
      as_hi3_q <= as_hi2_q;
    end
  end

  // min/max and merge with add/sub
  iau_res_t              res4_d;
  iau_res_t              sb_q [DLY];
  logic signed [Q_W-1:0] la3, lb3, ha3, hb3;

  always_comb begin
    la3 = la3_q[Q_W-1:0];
    lb3 = lb3_q[Q_W-1:0];
    ha3 = ha3_q[Q_W-1:0];
    hb3 = hb3_q[Q_W-1:0];
    res4_d.is_div = (op3_q == ACT_DIV);
    res4_d.derr   = derr3_q;
    if (op3_q inside {ACT_ADD, ACT_SUB}) begin
      res4_d.lo  = as_lo3_q[Q_W-1:0];
      res4_d.hi  = as_hi3_q[Q_W-1:0];
      res4_d.ovf = as_lo3_q[Q_W] | as_hi3_q[Q_W];
    end else begin
      res4_d.lo  = (la3 < lb3) ? la3 : lb3;
      res4_d.hi  = (ha3 > hb3) ? ha3 : hb3;
      res4_d.ovf = la3_q[Q_W] | lb3_q[Q_W] | ha3_q[Q_W] | hb3_q[Q_W];
    end
  end

  // m4 result register followed by the alignment delay
  iau_res_t res4_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      res4_q <= res4_d;
      sb_q[0] <= res4_q;
      for (int j = 1; j < DLY; j++) sb_q[j] <= sb_q[j-1];
    end
  end

  // dividers
  logic signed [Q_W-1:0] q_lo, q_hi;
  logic                  q_lo_ovf, q_hi_ovf;

  iau_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk_i    (clk_i),
    .ce_i     (ce),
    .num_i    (dn_lo),
    .den_i    (dd_lo),
    .rnd_up_i (1'b0),
    .quo_o    (q_lo),
    .ovf_o    (q_lo_ovf)
  );

  iau_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk_i    (clk_i),
    .ce_i     (ce),
    .num_i    (dn_hi),
    .den_i    (dd_hi),
    .rnd_up_i (1'b1),
    .quo_o    (q_hi),
    .ovf_o    (q_hi_ovf)
  );

  // valid bits beside the data
  logic [DL-1:0] vp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
      mv_q <= 1'b0;
    end else if (ce) begin
      vp_q <= {vp_q[DL-2:0], v1_q};
      mv_q <= vp_q[DL-1];
    end
  end

  // output register
  iau_res_t sbl;
  iau_res_t out_d, out_q;

  always_comb begin
    sbl   = sb_q[DLY-1];
    out_d = sbl;
    if (sbl.is_div) begin
      if (sbl.derr) begin
        out_d.lo  = '0;
        out_d.hi  = '0;
        out_d.ovf = 1'b0;
      end else begin
        out_d.lo  = q_lo;
        out_d.hi  = q_hi;
        out_d.ovf = q_lo_ovf | q_hi_ovf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {out_q.hi, out_q.lo};
  assign m_axis_tuser  = {out_q.ovf, out_q.derr};

endmodule

// File: rtl/iau_checker.sv
// iau_checker: port-level assertions for the interval arithmetic unit
// depends on interval_arithmetic_unit, attached by bind

module iau_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // pipeline moves only when the output slot frees
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");

  // divide error result is zero and never overflows
  a_derr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0 && !m_axis_tuser[1]))
    else $error("divide error with nonzero result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output transaction dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output changed");

endmodule

bind interval_arithmetic_unit iau_checker u_iau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
